// File: sv/pat_pkg.sv
package pat_pkg;

  // Configuration port geometry: eight 32-bit registers at word addresses.
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;

  // Register map, in word order.
  typedef enum logic [2:0] {
    REG_MODE     = 3'd0,
    REG_SHIFT_X  = 3'd1,
    REG_SHIFT_Y  = 3'd2,
    REG_SCALE_X  = 3'd3,
    REG_SCALE_Y  = 3'd4,
    REG_ANCHOR_X = 3'd5,
    REG_ANCHOR_Y = 3'd6,
    REG_ANGLE    = 3'd7
  } reg_idx_e;

  // Transform selection.
  typedef enum logic [1:0] {
    MODE_TRANSLATE    = 2'd0,
    MODE_SCALE        = 2'd1,
    MODE_SCALE_ANCHOR = 2'd2,
    MODE_ROTATE       = 2'd3
  } mode_e;

  // Scale factors are signed Q8.8.
  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned Q88_FRAC = 8;
  localparam int          Q88_ONE  = 256;

  // Angle register and degree constants.
  localparam int unsigned ANGLE_W     = 9;
  localparam int unsigned FULL_TURN   = 360;
  localparam int unsigned QUARTER_DEG = 90;

  // Quarter-wave sine table, round(sin(d) * 2^14) for d = 0..90 degrees.
  localparam int unsigned SINE_ROM_FRAC = 14;
  localparam int unsigned SINE_ROM_W    = 15;
  localparam int unsigned SINE_IDX_W    = 7;

  localparam logic [SINE_ROM_W-1:0] SINE_QUARTER [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

endpackage

// File: sv/pat_coef.sv
module pat_coef #(
  parameter int unsigned SINE_FRAC_BITS = 14
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [pat_pkg::ANGLE_W-1:0]      angle_i,
  output logic signed [SINE_FRAC_BITS+1:0] cos_o,
  output logic signed [SINE_FRAC_BITS+1:0] sin_o
);
  import pat_pkg::*;

  localparam int unsigned CW  = SINE_FRAC_BITS + 2;
  localparam int unsigned TW  = ((SINE_FRAC_BITS > SINE_ROM_FRAC) ?
                                 SINE_FRAC_BITS : SINE_ROM_FRAC) + 2;
  localparam int unsigned LSH = (SINE_FRAC_BITS > SINE_ROM_FRAC) ?
                                (SINE_FRAC_BITS - SINE_ROM_FRAC) : 0;
  localparam int unsigned RSH = (SINE_FRAC_BITS < SINE_ROM_FRAC) ?
                                (SINE_ROM_FRAC - SINE_FRAC_BITS) : 0;
  localparam int unsigned RND = (1 << RSH) >> 1;
  localparam logic signed [CW-1:0] ONE = CW'(64'd1 << SINE_FRAC_BITS);

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  logic [ANGLE_W-1:0]    deg;
  quad_e                 quad;
  logic [ANGLE_W-1:0]    rem_deg;
  logic [SINE_IDX_W-1:0] idx_a;
  logic [SINE_IDX_W-1:0] idx_b;
  logic signed [CW-1:0]  mag_a;
  logic signed [CW-1:0]  mag_b;
  logic signed [CW-1:0]  cos_d;
  logic signed [CW-1:0]  sin_d;
  logic signed [CW-1:0]  cos_q;
  logic signed [CW-1:0]  sin_q;

  // Table entry rescaled to the configured fraction, rounding half up when narrowing.
  function automatic logic signed [CW-1:0] table_value(input logic [SINE_IDX_W-1:0] idx);
    logic [TW-1:0] t;
    t = TW'(SINE_QUARTER[idx]);
    t = ((t + TW'(RND)) >> RSH) << LSH;
    return CW'(t);
  endfunction

  // Fold the angle into one turn and split it into quadrant and remainder.
  always_comb begin
    deg = (angle_i >= ANGLE_W'(FULL_TURN)) ? (angle_i - ANGLE_W'(FULL_TURN)) : angle_i;
    if (deg >= ANGLE_W'(3 * QUARTER_DEG)) begin
      quad    = QUAD_IV;
      rem_deg = deg - ANGLE_W'(3 * QUARTER_DEG);
    end else if (deg >= ANGLE_W'(2 * QUARTER_DEG)) begin
      quad    = QUAD_III;
      rem_deg = deg - ANGLE_W'(2 * QUARTER_DEG);
    end else if (deg >= ANGLE_W'(QUARTER_DEG)) begin
      quad    = QUAD_II;
      rem_deg = deg - ANGLE_W'(QUARTER_DEG);
    end else begin
      quad    = QUAD_I;
      rem_deg = deg;
    end
    idx_a = rem_deg[SINE_IDX_W-1:0];
    idx_b = SINE_IDX_W'(QUARTER_DEG) - idx_a;
    mag_a = table_value(idx_a);
    mag_b = table_value(idx_b);
  end

  // Signs and roles of the two table values depend on the quadrant.
  always_comb begin
    case (quad)
      QUAD_I: begin
        sin_d = mag_a;
        cos_d = mag_b;
      end
      QUAD_II: begin
        sin_d = mag_b;
        cos_d = -mag_a;
      end
      QUAD_III: begin
        sin_d = -mag_a;
        cos_d = -mag_b;
      end
      QUAD_IV: begin
        sin_d = -mag_b;
        cos_d = mag_a;
      end
      default: begin
        sin_d = '0;
        cos_d = ONE;
      end
    endcase
  end

  // Coefficients are registered so the lookup stays off the multiplier path.
  // Reset gives the values for the reset angle of zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cos_q <= ONE;
      sin_q <= '0;
    end else begin
      cos_q <= cos_d;
      sin_q <= sin_d;
    end
  end

  assign cos_o = cos_q;
  assign sin_o = sin_q;

`ifndef NO_ASSERTIONS
  a_zero_deg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(angle_i) == '0) |-> (cos_o == ONE && sin_o == '0))
    else $error("coefficients wrong for zero degrees");

  a_right_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(angle_i) == ANGLE_W'(QUARTER_DEG)) |-> (cos_o == '0 && sin_o == ONE))
    else $error("coefficients wrong for a right angle");

  a_half_turn: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(angle_i) == ANGLE_W'(2 * QUARTER_DEG)) |-> (cos_o == -ONE && sin_o == '0))
    else $error("coefficients wrong for a half turn");
`endif

endmodule

// File: sv/point_affine_transform_2d_top.sv
// Affine transform of 2D points: translate, scale, scale about an anchor, rotate.
// A request taken at a clock edge passes through the input register and the result
// register, and its result is held for one cycle with result_valid_o high.
// Throughput: one request per cycle; busy stays low since both register stages
// advance each cycle and the result receiver cannot stall.
// Reset: rst_ni clears the valid bits and restores register defaults.
module point_affine_transform_2d_top #(
  parameter int unsigned COORD_BITS     = 16,
  parameter int unsigned SINE_FRAC_BITS = 14
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [COORD_BITS-1:0]       x_in_i,
  input  logic signed [COORD_BITS-1:0]       y_in_i,
  input  logic                               last_point_i,
  output logic                               result_valid_o,
  output logic signed [COORD_BITS-1:0]       x_out_o,
  output logic signed [COORD_BITS-1:0]       y_out_o,
  output logic                               saturated_o,
  output logic                               last_out_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pat_pkg::ADDR_W-1:0]         paddr,
  input  logic [pat_pkg::DATA_W-1:0]         pwdata,
  output logic [pat_pkg::DATA_W-1:0]         prdata,
  output logic                               pready
);
  import pat_pkg::*;

  localparam int unsigned CW = SINE_FRAC_BITS + 2;
  localparam int unsigned KW = (CW > SCALE_W + 1) ? CW : (SCALE_W + 1);
  localparam int unsigned PW = COORD_BITS + KW;
  localparam int unsigned SW = PW + 2;
  localparam logic signed [COORD_BITS-1:0] SAT_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] SAT_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Configuration registers.
  mode_e                         mode_q;
  logic signed [COORD_BITS-1:0]  shift_x_q;
  logic signed [COORD_BITS-1:0]  shift_y_q;
  logic signed [SCALE_W-1:0]     scale_x_q;
  logic signed [SCALE_W-1:0]     scale_y_q;
  logic signed [COORD_BITS-1:0]  anchor_x_q;
  logic signed [COORD_BITS-1:0]  anchor_y_q;
  logic [ANGLE_W-1:0]            angle_q;
  logic                          cfg_wr;
  reg_idx_e                      cfg_idx;

  // Rotation coefficients.
  logic signed [CW-1:0]          cos_c;
  logic signed [CW-1:0]          sin_c;

  // Input stage.
  logic                          in_valid_q;
  logic signed [COORD_BITS-1:0]  x_q;
  logic signed [COORD_BITS-1:0]  y_q;
  logic                          last_q;

  // Operand selection and products.
  logic signed [KW-1:0]          one_k;
  logic signed [KW-1:0]          sx_k;
  logic signed [KW-1:0]          sy_k;
  logic signed [KW-1:0]          cos_k;
  logic signed [KW-1:0]          sin_k;
  logic signed [COORD_BITS-1:0]  opx_a;
  logic signed [COORD_BITS-1:0]  opx_b;
  logic signed [COORD_BITS-1:0]  opy_a;
  logic signed [COORD_BITS-1:0]  opy_b;
  logic signed [KW-1:0]          kx_a;
  logic signed [KW-1:0]          kx_b;
  logic signed [KW-1:0]          ky_a;
  logic signed [KW-1:0]          ky_b;
  logic signed [PW-1:0]          px_a_d;
  logic signed [PW-1:0]          px_b_d;
  logic signed [PW-1:0]          py_a_d;
  logic signed [PW-1:0]          py_b_d;

  // Sum and clip.
  logic signed [SW-1:0]          sum_x;
  logic signed [SW-1:0]          sum_y;
  logic signed [COORD_BITS-1:0]  x_d;
  logic signed [COORD_BITS-1:0]  y_d;
  logic                          sat_x;
  logic                          sat_y;

  // Result stage.
  logic                          res_valid_q;
  logic signed [COORD_BITS-1:0]  x_out_q;
  logic signed [COORD_BITS-1:0]  y_out_q;
  logic                          sat_q;
  logic                          last_out_q;

  // Round a product half up at the fraction of the current mode.
  function automatic logic signed [PW:0] round_term(input logic signed [PW-1:0] p,
                                                    input mode_e m);
    logic signed [PW:0] pe;
    logic signed [PW:0] r;
    pe = (PW+1)'(p);
    case (m)
      MODE_TRANSLATE: r = pe;
      MODE_SCALE, MODE_SCALE_ANCHOR:
        r = (pe + (PW+1)'(64'sd1 <<< (Q88_FRAC - 1))) >>> Q88_FRAC;
      MODE_ROTATE:
        r = (pe + (PW+1)'(64'sd1 <<< (SINE_FRAC_BITS - 1))) >>> SINE_FRAC_BITS;
      default: r = pe;
    endcase
    return r;
  endfunction

  // Saturate a wide sum into the coordinate range.
  function automatic logic [COORD_BITS:0] clip(input logic signed [SW-1:0] v);
    logic                          ovf;
    logic signed [COORD_BITS-1:0]  c;
    ovf = (v[SW-1:COORD_BITS-1] != {(SW-COORD_BITS+1){1'b0}}) &&
          (v[SW-1:COORD_BITS-1] != {(SW-COORD_BITS+1){1'b1}});
    if (ovf) begin
      c = v[SW-1] ? SAT_MIN : SAT_MAX;
    end else begin
      c = v[COORD_BITS-1:0];
    end
    return {ovf, c};
  endfunction

  // The configuration port never waits, and the pipeline never stalls.
  assign pready = 1'b1;
  assign busy   = 1'b0;

  // Register writes.
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_TRANSLATE;
      shift_x_q  <= '0;
      shift_y_q  <= '0;
      scale_x_q  <= SCALE_W'(Q88_ONE);
      scale_y_q  <= SCALE_W'(Q88_ONE);
      anchor_x_q <= '0;
      anchor_y_q <= '0;
      angle_q    <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_MODE:     mode_q     <= mode_e'(pwdata[1:0]);
        REG_SHIFT_X:  shift_x_q  <= pwdata[COORD_BITS-1:0];
        REG_SHIFT_Y:  shift_y_q  <= pwdata[COORD_BITS-1:0];
        REG_SCALE_X:  scale_x_q  <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y:  scale_y_q  <= pwdata[SCALE_W-1:0];
        REG_ANCHOR_X: anchor_x_q <= pwdata[COORD_BITS-1:0];
        REG_ANCHOR_Y: anchor_y_q <= pwdata[COORD_BITS-1:0];
        REG_ANGLE:    angle_q    <= pwdata[ANGLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads return the stored bits, zero-extended.
  always_comb begin
    case (cfg_idx)
      REG_MODE:     prdata = DATA_W'(mode_q);
      REG_SHIFT_X:  prdata = DATA_W'($unsigned(shift_x_q));
      REG_SHIFT_Y:  prdata = DATA_W'($unsigned(shift_y_q));
      REG_SCALE_X:  prdata = DATA_W'($unsigned(scale_x_q));
      REG_SCALE_Y:  prdata = DATA_W'($unsigned(scale_y_q));
      REG_ANCHOR_X: prdata = DATA_W'($unsigned(anchor_x_q));
      REG_ANCHOR_Y: prdata = DATA_W'($unsigned(anchor_y_q));
      REG_ANGLE:    prdata = DATA_W'(angle_q);
      default:      prdata = '0;
    endcase
  end

  // Sine and cosine for the configured angle.
  pat_coef #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_coef (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .angle_i(angle_q),
    .cos_o  (cos_c),
    .sin_o  (sin_c)
  );

  // Input register: a request is taken in every cycle that start is high.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      x_q    <= x_in_i;
      y_q    <= y_in_i;
      last_q <= last_point_i;
    end
  end

  // Each output is the sum of two products; the mode picks their operands.
  always_comb begin
    one_k = KW'(1);
    sx_k  = KW'(scale_x_q);
    sy_k  = KW'(scale_y_q);
    cos_k = KW'(cos_c);
    sin_k = KW'(sin_c);
    case (mode_q)
      MODE_TRANSLATE: begin
        opx_a = x_q;         kx_a = one_k;
        opx_b = shift_x_q;   kx_b = one_k;
        opy_a = y_q;         ky_a = one_k;
        opy_b = shift_y_q;   ky_b = one_k;
      end
      MODE_SCALE: begin
        opx_a = x_q;         kx_a = sx_k;
        opx_b = '0;          kx_b = '0;
        opy_a = y_q;         ky_a = sy_k;
        opy_b = '0;          ky_b = '0;
      end
      MODE_SCALE_ANCHOR: begin
        opx_a = x_q;         kx_a = sx_k;
        opx_b = anchor_x_q;  kx_b = KW'(Q88_ONE) - sx_k;
        opy_a = y_q;         ky_a = sy_k;
        opy_b = anchor_y_q;  ky_b = KW'(Q88_ONE) - sy_k;
      end
      MODE_ROTATE: begin
        opx_a = x_q;         kx_a = cos_k;
        opx_b = y_q;         kx_b = -sin_k;
        opy_a = x_q;         ky_a = sin_k;
        opy_b = y_q;         ky_b = cos_k;
      end
      default: begin
        opx_a = x_q;         kx_a = one_k;
        opx_b = '0;          kx_b = '0;
        opy_a = y_q;         ky_a = one_k;
        opy_b = '0;          ky_b = '0;
      end
    endcase
    px_a_d = PW'(opx_a) * PW'(kx_a);
    px_b_d = PW'(opx_b) * PW'(kx_b);
    py_a_d = PW'(opy_a) * PW'(ky_a);
    py_b_d = PW'(opy_b) * PW'(ky_b);
  end

  // Round each product, add the pair and saturate.
  always_comb begin
    sum_x = SW'(round_term(px_a_d, mode_q)) + SW'(round_term(px_b_d, mode_q));
    sum_y = SW'(round_term(py_a_d, mode_q)) + SW'(round_term(py_b_d, mode_q));
    {sat_x, x_d} = clip(sum_x);
    {sat_y, y_d} = clip(sum_y);
  end

  // Result register: holds each result for exactly one cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    x_out_q    <= x_d;
    y_out_q    <= y_d;
    sat_q      <= sat_x || sat_y;
    last_out_q <= last_q;
  end

  assign result_valid_o = res_valid_q;
  assign x_out_o        = x_out_q;
  assign y_out_o        = y_out_q;
  assign saturated_o    = sat_q;
  assign last_out_o     = last_out_q;

`ifndef NO_ASSERTIONS
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 result_valid_o)
    else $error("request did not produce a result after the pipeline latency");

  a_sat_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && saturated_o) |->
      (x_out_o == SAT_MAX || x_out_o == SAT_MIN || y_out_o == SAT_MAX ||
       y_out_o == SAT_MIN))
    else $error("saturation flagged without a clipped coordinate");

  a_translate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !saturated_o && mode_q == MODE_TRANSLATE) |->
      (x_out_o == COORD_BITS'($past(x_q) + shift_x_q)))
    else $error("translated x does not match the input point");
`endif

endmodule
